// ===== rtl/core/kti_pkg.sv =====
package kti_pkg;

  localparam int MAX_KEYS_DEF = 16;
  localparam int KEY_WORDS    = 11;
  localparam logic signed [33:0] FX_ONE = 34'sd65536;

  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_APPEND = 2'd1,
    REQ_QUERY  = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_STORE,
    ST_RD_FIRST,
    ST_RD_LAST,
    ST_CLAMP,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_DIV,
    ST_LERP_RD,
    ST_LERP_MUL,
    ST_QMUL,
    ST_RSUM,
    ST_MMUL,
    ST_EMIT
  } state_t;

  function automatic logic signed [31:0] sat32(input logic signed [67:0] x);
    if (x > 68'sd2147483647) return 32'sh7fffffff;
    else if (x < -68'sd2147483648) return 32'sh80000000;
    else return x[31:0];
  endfunction

endpackage

// ===== rtl/core/keyframe_trs_interpolator_core.sv =====
// Requests: clear resets the key count; append makes 11 word writes; a query emits
//   at once on an empty table, skips the scan and divider when clamped, and otherwise
//   scans keys and divides before emitting; rows then go one per transfer.
// Throughput: one item at a time; the key memory port, one shared 34x34 multiplier
//   and a 48-step restoring divider set the cycle count.
// Reset: rst clears the key count and the sequencer; key words are not cleared.
module keyframe_trs_interpolator_core #(
  parameter int MAX_KEYS = kti_pkg::MAX_KEYS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // time_pos, trans_x/y/z, scale_x/y/z, quat_x/y/z/w (lowest bits first)
  input  logic [351:0] s_tdata,
  // req_type
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // elem_0, elem_1, elem_2, elem_3
  output logic [127:0] m_tdata,
  // row_index
  output logic [1:0]   m_tuser,
  output logic         m_tlast
);
  import kti_pkg::*;

  localparam int DEPTH = MAX_KEYS * KEY_WORDS;
  localparam int AW    = $clog2(DEPTH);
  localparam int KW    = $clog2(MAX_KEYS + 1);
  localparam int IW    = $clog2(MAX_KEYS);

  state_t state, state_next;

  logic signed [31:0] mem [DEPTH];
  logic        [AW-1:0] addr;
  logic signed [31:0] rdata;
  logic        mem_we;
  logic [3:0]  wsel;

  logic [KW-1:0] key_count;
  logic [351:0]  in_data;
  logic signed [31:0] qt;
  logic [IW-1:0] seg;
  logic [3:0]    sub;
  logic [5:0]    cnt;
  logic          is_id;

  logic signed [31:0] t0, t1, aw;
  logic signed [31:0] v [10];
  logic        [16:0] f;
  logic [47:0] rem_q;
  logic [32:0] dividend_rem;
  logic [32:0] den;
  logic [47:0] quot;

  logic signed [33:0] ma, mb;
  logic signed [67:0] mp;
  logic signed [47:0] pr [9];
  logic signed [31:0] rm [9];
  logic signed [31:0] mm [9];
  logic [1:0]  row;

  logic        s_fire, m_fire;
  assign s_fire = s_tvalid && s_tready;
  assign m_fire = m_tvalid && m_tready;
  assign s_tready = (state == ST_IDLE);

  assign mp = ma * mb;

  function automatic logic signed [51:0] fl16(input logic signed [67:0] x);
    return x[67:16];
  endfunction

  always_ff @(posedge clk) begin
    if (mem_we) mem[addr] <= in_data[wsel*32 +: 32];
    rdata <= mem[addr];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (s_fire) begin
        unique case (req_t'(s_tuser))
          REQ_APPEND: state_next = (key_count < KW'(MAX_KEYS)) ? ST_STORE : ST_IDLE;
          REQ_QUERY:  state_next = (key_count == '0) ? ST_EMIT : ST_RD_FIRST;
          default:    state_next = ST_IDLE;
        endcase
      end
      ST_STORE:    if (sub == 4'(KEY_WORDS - 1)) state_next = ST_IDLE;
      ST_RD_FIRST: if (cnt == 6'd1) state_next = ST_RD_LAST;
      ST_RD_LAST:  if (cnt == 6'd1) state_next = ST_CLAMP;
      ST_CLAMP:    state_next = (qt <= t0 || qt >= t1) ? ST_LERP_RD : ST_SCAN_RD;
      ST_SCAN_RD:  if (cnt == 6'd2) state_next = ST_SCAN_CHK;
      ST_SCAN_CHK: begin
        if (qt >= t0 && qt <= t1) state_next = ST_DIV;
        else if (32'(seg) + 2 >= 32'(key_count)) state_next = ST_EMIT;
        else state_next = ST_SCAN_RD;
      end
      ST_DIV:      if (cnt == 6'd47) state_next = ST_LERP_RD;
      ST_LERP_RD:  if (cnt == 6'd2) state_next = ST_LERP_MUL;
      ST_LERP_MUL: state_next = (sub == 4'd9) ? ST_QMUL : ST_LERP_RD;
      ST_QMUL:     if (sub == 4'd8) state_next = ST_RSUM;
      ST_RSUM:     state_next = ST_MMUL;
      ST_MMUL:     if (sub == 4'd8) state_next = ST_EMIT;
      ST_EMIT:     if (m_fire && row == 2'd3) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    mem_we = (state == ST_STORE);
    wsel = sub;
    addr = '0;
    ma = '0;
    mb = '0;
    unique case (state)
      ST_STORE:    addr = AW'(key_count * KEY_WORDS + sub);
      ST_RD_FIRST: addr = '0;
      ST_RD_LAST:  addr = AW'((key_count - 1'b1) * KEY_WORDS);
      ST_SCAN_RD:  addr = AW'((seg + (cnt == 6'd0 ? 0 : 1)) * KEY_WORDS);
      // zero fraction reads the same key twice so no key past the table is touched
      ST_LERP_RD:  addr = AW'((seg + ((cnt == 6'd0 || f == '0) ? 0 : 1)) * KEY_WORDS
                              + sub + 1);
      ST_LERP_MUL: begin
        ma = 34'(f);
        mb = 34'(rdata) - 34'(aw);
      end
      ST_QMUL: begin
        unique case (sub)
          4'd0: begin ma = 34'(v[6]); mb = 34'(v[6]); end
          4'd1: begin ma = 34'(v[7]); mb = 34'(v[7]); end
          4'd2: begin ma = 34'(v[8]); mb = 34'(v[8]); end
          4'd3: begin ma = 34'(v[6]); mb = 34'(v[7]); end
          4'd4: begin ma = 34'(v[6]); mb = 34'(v[8]); end
          4'd5: begin ma = 34'(v[7]); mb = 34'(v[8]); end
          4'd6: begin ma = 34'(v[9]); mb = 34'(v[6]); end
          4'd7: begin ma = 34'(v[9]); mb = 34'(v[7]); end
          default: begin ma = 34'(v[9]); mb = 34'(v[8]); end
        endcase
      end
      ST_MMUL: begin
        ma = 34'(rm[sub]);
        unique case (sub)
          4'd0, 4'd3, 4'd6: mb = 34'(v[3]);
          4'd1, 4'd4, 4'd7: mb = 34'(v[4]);
          default:          mb = 34'(v[5]);
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      key_count <= '0;
      sub <= '0;
      cnt <= '0;
      row <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: begin
          sub <= '0;
          cnt <= '0;
          row <= '0;
          if (s_fire) begin
            in_data <= s_tdata;
            qt <= s_tdata[31:0];
            seg <= '0;
            is_id <= 1'b1;
            if (req_t'(s_tuser) == REQ_CLEAR) key_count <= '0;
          end
        end
        ST_STORE: begin
          sub <= sub + 1'b1;
          if (sub == 4'(KEY_WORDS - 1)) key_count <= key_count + 1'b1;
        end
        ST_RD_FIRST: begin
          cnt <= (cnt == 6'd1) ? 6'd0 : cnt + 1'b1;
          if (cnt == 6'd1) t0 <= rdata;
        end
        ST_RD_LAST: begin
          cnt <= (cnt == 6'd1) ? 6'd0 : cnt + 1'b1;
          if (cnt == 6'd1) t1 <= rdata;
        end
        ST_CLAMP: begin
          f <= '0;
          sub <= '0;
          is_id <= 1'b0;
          if (qt <= t0) seg <= '0;
          else if (qt >= t1) seg <= IW'(key_count - 1'b1);
          else is_id <= 1'b1;
        end
        ST_SCAN_RD: begin
          cnt <= (cnt == 6'd2) ? 6'd0 : cnt + 1'b1;
          if (cnt == 6'd1) t0 <= rdata;
          if (cnt == 6'd2) t1 <= rdata;
        end
        ST_SCAN_CHK: begin
          cnt <= '0;
          if (qt >= t0 && qt <= t1) begin
            is_id <= 1'b0;
            den <= 33'(t1) - 33'(t0);
            dividend_rem <= '0;
            quot <= '0;
            rem_q <= {16'(33'(qt) - 33'(t0) >> 16), 16'(33'(qt) - 33'(t0)), 16'd0};
          end else if (32'(seg) + 2 < 32'(key_count)) seg <= seg + 1'b1;
        end
        ST_DIV: begin
          logic [33:0] trial;
          trial = {dividend_rem, rem_q[47]} - {1'b0, den};
          rem_q <= rem_q << 1;
          if (!trial[33]) begin
            dividend_rem <= trial[32:0];
            quot <= {quot[46:0], 1'b1};
          end else begin
            dividend_rem <= {dividend_rem[31:0], rem_q[47]};
            quot <= {quot[46:0], 1'b0};
          end
          cnt <= (cnt == 6'd47) ? 6'd0 : cnt + 1'b1;
          if (cnt == 6'd47) begin
            sub <= '0;
            f <= (den == '0) ? '0 : 17'({quot[46:0], !trial[33]});
          end
        end
        ST_LERP_RD: begin
          cnt <= cnt + 1'b1;
          if (cnt == 6'd1) aw <= rdata;
        end
        ST_LERP_MUL: begin
          cnt <= '0;
          v[sub] <= 32'(52'(aw) + fl16(mp));
          sub <= (sub == 4'd9) ? 4'd0 : sub + 1'b1;
        end
        ST_QMUL: begin
          pr[sub] <= 48'(fl16(mp));
          sub <= (sub == 4'd8) ? 4'd0 : sub + 1'b1;
        end
        ST_RSUM: begin
          rm[0] <= sat32(68'(FX_ONE) - 68'(pr[1]) * 2 - 68'(pr[2]) * 2);
          rm[1] <= sat32((68'(pr[3]) - 68'(pr[8])) * 2);
          rm[2] <= sat32((68'(pr[4]) + 68'(pr[7])) * 2);
          rm[3] <= sat32((68'(pr[3]) + 68'(pr[8])) * 2);
          rm[4] <= sat32(68'(FX_ONE) - 68'(pr[0]) * 2 - 68'(pr[2]) * 2);
          rm[5] <= sat32((68'(pr[5]) - 68'(pr[6])) * 2);
          rm[6] <= sat32((68'(pr[4]) - 68'(pr[7])) * 2);
          rm[7] <= sat32((68'(pr[5]) + 68'(pr[6])) * 2);
          rm[8] <= sat32(68'(FX_ONE) - 68'(pr[0]) * 2 - 68'(pr[1]) * 2);
        end
        ST_MMUL: begin
          mm[sub] <= sat32(68'(fl16(mp)));
          sub <= (sub == 4'd8) ? 4'd0 : sub + 1'b1;
        end
        ST_EMIT: if (m_fire) row <= row + 1'b1;
        default: ;
      endcase
    end
  end

  always_comb begin
    m_tvalid = (state == ST_EMIT);
    m_tuser = row;
    m_tlast = (row == 2'd3);
    m_tdata = '0;
    if (row == 2'd3) m_tdata[127:96] = 32'(FX_ONE);
    else if (is_id || key_count == '0) m_tdata[32*row +: 32] = 32'(FX_ONE);
    else m_tdata = {v[row], mm[row*3+2], mm[row*3+1], mm[row*3]};
  end

`ifndef SYNTHESIS
  a_cnt_max: assert property (@(posedge clk) disable iff (rst)
    key_count <= KW'(MAX_KEYS)) else $error("key count overflow");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready) else $error("ready while emitting");
  a_row_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> $stable(row)) else $error("row moved on stall");
  a_last_ret: assert property (@(posedge clk) disable iff (rst)
    (m_fire && m_tlast) |=> s_tready) else $error("not idle after last row");
`endif

endmodule
